/* src/fsrc_pkg.sv */
// Shared types, constants and the CRC-8 step for the framed serial receiver.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package fsrc_pkg;

  // payload buffer depth and its address width
  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // CRC-8, polynomial x^8+x^2+x+1, MSB first
  localparam logic [7:0] CRC_POLY = 8'h07;

  // register reset values
  localparam logic [7:0] SYNC_RESET = 8'hA5;
  localparam logic [7:0] SEED_RESET = 8'h00;

  // result event codes
  localparam logic [1:0] EV_DATA    = 2'd0;
  localparam logic [1:0] EV_EMPTY   = 2'd1;
  localparam logic [1:0] EV_BADCRC  = 2'd2;
  localparam logic [1:0] EV_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [31:0] bytes_seen;
    logic [31:0] frames_good;
    logic [31:0] sync_misses;
    logic [31:0] crc_failures;
    logic [31:0] length_overruns;
  } stats_t;

  // one frame outcome handed from front to back
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] frame_type;
    logic [7:0] frame_len;
    stats_t     stats;
  } job_t;

  // payload buffer write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // fold one byte into the running CRC
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/fsrc_in_if.sv */
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
interface fsrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* src/fsrc_out_if.sv */
// Result channel: valid/ready handshake carrying one frame result.
// Depends on nothing.
interface fsrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  frame_type;
  logic [7:0]  frame_len;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic [31:0] bytes_seen;
  logic [31:0] frames_good;
  logic [31:0] sync_misses;
  logic [31:0] crc_failures;
  logic [31:0] length_overruns;

  modport source (
    output valid, output event_res, output frame_type, output frame_len,
    output data_byte, output byte_index, output last, output bytes_seen,
    output frames_good, output sync_misses, output crc_failures,
    output length_overruns, input ready
  );
  modport sink (
    input valid, input event_res, input frame_type, input frame_len,
    input data_byte, input byte_index, input last, input bytes_seen,
    input frames_good, input sync_misses, input crc_failures,
    input length_overruns, output ready
  );
endinterface

/* src/framed_serial_receiver_crc8.sv */
// Top level of the framed serial receiver with CRC-8 check.
// Depends on fsrc_pkg, fsrc_in_if, fsrc_out_if, fsrc_front, fsrc_job_q, fsrc_back.
//
//   channel  | dir | handshake            | beat
//   in_ch    | in  | valid/ready          | rx_byte
//   out_ch   | out | valid/ready          | one frame result with counters
//   APB      | in  | psel/penable, pready | sync_byte @0x0, crc_seed @0x4
//
// Flow: input bytes are taken while in_ch.ready is high; a result is loaded into
// the output register only once it is empty, from the registered buffer read.
// Reset: synchronous; the payload buffer is not cleared (only bytes of the
// current frame are read). in_ch.ready drops while the job queue is full or
// while a payload byte arrives before the previous frame's readout has ended.
module framed_serial_receiver_crc8 (
  input  logic        clk,
  input  logic        rst,
  fsrc_in_if.sink     in_ch,
  fsrc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_SEED = 1'b1;

  fsrc_pkg::cfg_t    cfg;
  fsrc_pkg::job_t    push_job;
  fsrc_pkg::job_t    q_job;
  fsrc_pkg::mem_wr_t mem_wr;
  logic              push, pop, q_valid, q_full, done;
  logic              wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte <= fsrc_pkg::SYNC_RESET;
      cfg.crc_seed  <= fsrc_pkg::SEED_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SYNC: cfg.sync_byte <= pwdata[7:0];
        REG_SEED: cfg.crc_seed  <= pwdata[7:0];
        default:  cfg.sync_byte <= cfg.sync_byte;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SYNC: prdata = {24'd0, cfg.sync_byte};
      REG_SEED: prdata = {24'd0, cfg.crc_seed};
      default:  prdata = 32'd0;
    endcase
  end

  fsrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_full   (q_full),
    .done     (done),
    .push     (push),
    .push_job (push_job),
    .mem_wr   (mem_wr)
  );

  fsrc_job_q u_job_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  fsrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mem_wr  (mem_wr),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .done    (done),
    .out_ch  (out_ch)
  );

endmodule

/* src/fsrc_front.sv */
// Front end: sync hunt, header parse, running CRC, statistics, buffer writes.
// Depends on fsrc_pkg and fsrc_in_if; pushes one job per finished frame.
module fsrc_front (
  input  logic                clk,
  input  logic                rst,
  fsrc_in_if.sink             in_ch,
  input  fsrc_pkg::cfg_t      cfg,
  input  logic                q_full,
  input  logic                done,
  output logic                push,
  output fsrc_pkg::job_t      push_job,
  output fsrc_pkg::mem_wr_t   mem_wr
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0]       phase, phase_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_length, held_length_next;
  logic [6:0]       fill, fill_next;
  logic [7:0]       crc, crc_next;
  fsrc_pkg::stats_t stats, stats_next;
  logic             pend;
  logic             acc;
  logic [7:0]       b;
  logic [6:0]       fill_inc;

  // a payload byte must wait while the last frame is still being read out
  assign in_ch.ready = !q_full && !((phase == PH_DATA) && pend);
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign fill_inc    = fill + 7'd1;

  // per-byte decode
  always_comb begin
    phase_next       = phase;
    held_type_next   = held_type;
    held_length_next = held_length;
    fill_next        = fill;
    crc_next         = crc;
    stats_next       = stats;
    push             = 1'b0;
    push_job.ev      = fsrc_pkg::EV_DATA;
    mem_wr.we        = 1'b0;
    mem_wr.addr      = fill[fsrc_pkg::ADDR_W-1:0];
    mem_wr.data      = b;
    if (acc) begin
      stats_next.bytes_seen = stats.bytes_seen + 32'd1;
      case (phase)
        PH_TYPE: begin
          held_type_next = b;
          crc_next       = fsrc_pkg::crc_fold(cfg.crc_seed, b);
          phase_next     = PH_LEN;
        end
        PH_LEN: begin
          held_length_next = b;
          fill_next        = 7'd0;
          if (b > 8'(fsrc_pkg::MAX_PAYLOAD)) begin
            stats_next.length_overruns = stats.length_overruns + 32'd1;
            push        = 1'b1;
            push_job.ev = fsrc_pkg::EV_OVERRUN;
            phase_next  = PH_HUNT;
          end else begin
            crc_next   = fsrc_pkg::crc_fold(crc, b);
            phase_next = (b == 8'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          mem_wr.we = (fill < 7'(fsrc_pkg::MAX_PAYLOAD));
          crc_next  = fsrc_pkg::crc_fold(crc, b);
          fill_next = fill_inc;
          if ({1'b0, fill_inc} >= held_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          push = 1'b1;
          if (crc == b) begin
            stats_next.frames_good = stats.frames_good + 32'd1;
            push_job.ev = (held_length == 8'd0) ? fsrc_pkg::EV_EMPTY : fsrc_pkg::EV_DATA;
          end else begin
            stats_next.crc_failures = stats.crc_failures + 32'd1;
            push_job.ev = fsrc_pkg::EV_BADCRC;
          end
          phase_next = PH_HUNT;
          fill_next  = 7'd0;
        end
        default: begin
          if (b == cfg.sync_byte) begin
            phase_next = PH_TYPE;
          end else begin
            stats_next.sync_misses = stats.sync_misses + 32'd1;
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
    push_job.frame_type = held_type_next;
    push_job.frame_len  = held_length_next;
    push_job.stats      = stats_next;
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_type   <= 8'd0;
      held_length <= 8'd0;
      fill        <= 7'd0;
      crc         <= 8'd0;
      stats       <= '0;
      pend        <= 1'b0;
    end else begin
      phase       <= phase_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      fill        <= fill_next;
      crc         <= crc_next;
      stats       <= stats_next;
      // a payload run is outstanding from its push until the back finishes it
      if (push && (push_job.ev == fsrc_pkg::EV_DATA)) begin
        pend <= 1'b1;
      end else if (done) begin
        pend <= 1'b0;
      end
    end
  end

  a_no_write_during_readout: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we |-> !pend)
    else $error("payload buffer written while a readout is outstanding");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

  a_check_pushes: assert property (@(posedge clk) disable iff (rst)
    (acc && (phase == PH_CHECK)) |-> push)
    else $error("CRC byte produced no job");

endmodule

/* src/fsrc_job_q.sv */
// Short job queue between front end and readout back end.
// Depends on fsrc_pkg for the job type and depth.
module fsrc_job_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsrc_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output fsrc_pkg::job_t q_job
);

  fsrc_pkg::job_t                  entries [fsrc_pkg::QDEPTH];
  logic [fsrc_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [fsrc_pkg::QCNT_W-1:0]     count;

  assign q_valid = (count != '0);
  assign q_full  = (count == fsrc_pkg::QCNT_W'(fsrc_pkg::QDEPTH));
  assign q_job   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == fsrc_pkg::QPTR_W'(fsrc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == fsrc_pkg::QPTR_W'(fsrc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty job queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fsrc_pkg::QCNT_W'(fsrc_pkg::QDEPTH))
    else $error("job queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("job queue count did not follow a push");

endmodule

/* src/fsrc_back.sv */
// Back end: payload buffer and result sequencer with an output register.
// Depends on fsrc_pkg and fsrc_out_if; takes jobs from the queue.
module fsrc_back (
  input  logic              clk,
  input  logic              rst,
  input  fsrc_pkg::mem_wr_t mem_wr,
  input  logic              q_valid,
  input  fsrc_pkg::job_t    q_job,
  output logic              pop,
  output logic              done,
  fsrc_out_if.source        out_ch
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [7:0]                  mem [fsrc_pkg::MAX_PAYLOAD];
  logic [7:0]                  rdata;
  logic [fsrc_pkg::ADDR_W-1:0] rd_addr;
  logic                        state;
  fsrc_pkg::job_t              cur;
  logic [5:0]                  idx;
  logic                        out_valid;
  logic                        load_run;
  logic                        run_last;

  fsrc_pkg::job_t              res_job;
  logic [7:0]                  res_data;
  logic [5:0]                  res_idx;
  logic                        res_last;

  assign pop      = (state == S_IDLE) && q_valid && !out_valid;
  assign load_run = (state == S_RUN) && !out_valid;
  assign run_last = (8'({2'b00, idx}) + 8'd1 == cur.frame_len);
  assign done     = load_run && run_last;

  // read address: entry 0 while idle, the next entry when one is being emitted, else hold
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = '0;
    end else if (load_run) begin
      rd_addr = fsrc_pkg::ADDR_W'(idx + 6'd1);
    end else begin
      rd_addr = fsrc_pkg::ADDR_W'(idx);
    end
  end

  // payload buffer
  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= 6'd0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            idx <= 6'd0;
            if (q_job.ev == fsrc_pkg::EV_DATA) begin
              state <= S_RUN;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_RUN: begin
          if (load_run) begin
            out_valid <= 1'b1;
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 6'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (pop && (q_job.ev != fsrc_pkg::EV_DATA)) begin
      res_job  <= q_job;
      res_data <= 8'd0;
      res_idx  <= 6'd0;
      res_last <= 1'b1;
    end else if (load_run) begin
      res_job  <= cur;
      res_data <= rdata;
      res_idx  <= idx;
      res_last <= run_last;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.event_res       = res_job.ev;
  assign out_ch.frame_type      = res_job.frame_type;
  assign out_ch.frame_len       = res_job.frame_len;
  assign out_ch.data_byte       = res_data;
  assign out_ch.byte_index      = res_idx;
  assign out_ch.last            = res_last;
  assign out_ch.bytes_seen      = res_job.stats.bytes_seen;
  assign out_ch.frames_good     = res_job.stats.frames_good;
  assign out_ch.sync_misses     = res_job.stats.sync_misses;
  assign out_ch.crc_failures    = res_job.stats.crc_failures;
  assign out_ch.length_overruns = res_job.stats.length_overruns;

  a_done_shows_last: assert property (@(posedge clk) disable iff (rst)
    done |=> (out_valid && res_last))
    else $error("end of readout without a last beat");

  a_run_is_payload: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (cur.ev == fsrc_pkg::EV_DATA))
    else $error("readout running for a non-payload job");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    (pop || load_run) |-> !out_valid)
    else $error("output register overwritten");

endmodule

/* tb/sv/tb_framed_serial_receiver_crc8.sv */
// Self-checking testbench for framed_serial_receiver_crc8: a directed byte table, a seed
// change mid-frame, then randomized framed traffic under several register settings.
// Depends on fsrc_pkg, fsrc_in_if, fsrc_out_if and the framed_serial_receiver_crc8 RTL.
module tb_framed_serial_receiver_crc8;
  import fsrc_pkg::*;

  // register byte addresses on the APB port
  localparam logic [2:0] SYNC_ADDR = 3'd0;
  localparam logic [2:0] SEED_ADDR = 3'd4;
  localparam int DIR_ROWS = 28;

  typedef enum logic [2:0] {
    RX_HUNT, RX_TYPE, RX_LEN, RX_DATA, RX_CHECK
  } rx_phase_e;

  // how a directed row builds its byte
  typedef enum logic [1:0] {ROW_RAW, ROW_GOOD_CRC, ROW_BAD_CRC} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;   // raw byte, or xor mask for a corrupted CRC
    logic       typed;   // row carries a typed-in expectation
    logic [1:0] ev;
    logic [7:0] flen;
  } dir_row_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] ftype;
    logic [7:0] flen;
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
    stats_t     stats;
  } rx_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fsrc_in_if  in_ch ();
  fsrc_out_if out_ch ();

  framed_serial_receiver_crc8 dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // deframer shadow state
  rx_phase_e   rx_phase;
  logic [7:0]  cur_type;
  logic [7:0]  cur_len;
  logic [6:0]  fill_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  payload_copy [MAX_PAYLOAD];
  stats_t      tally;
  logic [7:0]  sync_reg;
  logic [7:0]  seed_reg;

  rx_result_t  expected_results [$];
  int          mismatch_count;
  int          bytes_sent;
  rx_result_t  newest_result;
  bit          idle_en;
  int          hold_cycles;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_RAW,      8'h00,      1'b0, EV_DATA,    8'd0},   // miss while hunting
    '{ROW_RAW,      8'hFF,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h3C,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'd65,      1'b1, EV_OVERRUN, 8'd65},  // one past the max
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'hFF,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'hFF,      1'b1, EV_OVERRUN, 8'd255},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h00,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h00,      1'b0, EV_DATA,    8'd0},   // zero length
    '{ROW_GOOD_CRC, 8'h00,      1'b1, EV_EMPTY,   8'd0},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h81,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h00,      1'b0, EV_DATA,    8'd0},
    '{ROW_BAD_CRC,  8'h80,      1'b1, EV_BADCRC,  8'd0},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h12,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h03,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h00,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'hFF,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},   // sync value as payload
    '{ROW_GOOD_CRC, 8'h00,      1'b1, EV_DATA,    8'd3},
    '{ROW_RAW,      SYNC_RESET, 1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h07,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h01,      1'b0, EV_DATA,    8'd0},
    '{ROW_RAW,      8'h5A,      1'b0, EV_DATA,    8'd0},
    '{ROW_BAD_CRC,  8'h01,      1'b1, EV_BADCRC,  8'd1}
  };

  always #4 clk = ~clk;

  // CRC-8 x^8+x^2+x+1, shifted MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc ^ b;
    repeat (8) begin
      fb = r[7];
      r  = r << 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void push_result(input logic [1:0] ev, input logic [7:0] data,
                                      input logic [5:0] idx, input logic last);
    rx_result_t r;
    r.ev    = ev;
    r.ftype = cur_type;
    r.flen  = cur_len;
    r.data  = data;
    r.idx   = idx;
    r.last  = last;
    r.stats = tally;
    expected_results.push_back(r);
    newest_result = r;
  endfunction

  // advance the shadow deframer by one accepted byte, queue what it emits
  function automatic void predict_rx_byte(input logic [7:0] b);
    tally.bytes_seen += 1;
    case (rx_phase)
      RX_TYPE: begin
        cur_type = b;
        crc_acc  = crc8_step(seed_reg, b);
        rx_phase = RX_LEN;
      end
      RX_LEN: begin
        cur_len  = b;
        fill_pos = '0;
        if (b > MAX_PAYLOAD) begin
          tally.length_overruns += 1;
          push_result(EV_OVERRUN, 8'h00, 6'd0, 1'b1);
          rx_phase = RX_HUNT;
        end else begin
          crc_acc  = crc8_step(crc_acc, b);
          rx_phase = (b == 8'd0) ? RX_CHECK : RX_DATA;
        end
      end
      RX_DATA: begin
        payload_copy[fill_pos[5:0]] = b;
        crc_acc  = crc8_step(crc_acc, b);
        fill_pos = fill_pos + 7'd1;
        if (fill_pos >= cur_len) rx_phase = RX_CHECK;
      end
      RX_CHECK: begin
        if (crc_acc == b) begin
          tally.frames_good += 1;
          if (cur_len == 8'd0) begin
            push_result(EV_EMPTY, 8'h00, 6'd0, 1'b1);
          end else begin
            for (int i = 0; i < cur_len; i++)
              push_result(EV_DATA, payload_copy[i], i[5:0], (i + 1 == cur_len));
          end
        end else begin
          tally.crc_failures += 1;
          push_result(EV_BADCRC, 8'h00, 6'd0, 1'b1);
        end
        rx_phase = RX_HUNT;
        fill_pos = '0;
      end
      default: begin
        if (b == sync_reg) begin
          rx_phase = RX_TYPE;
        end else begin
          tally.sync_misses += 1;
          rx_phase = RX_HUNT;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // offer one byte, hold it until the handshake, then update the prediction
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    newest_result = 'x;
    predict_rx_byte(b);
    bytes_sent++;
  endtask

  // sync, type, length, payload, CRC; an overlong length ends the frame early, a cut frame stops before its CRC
  task automatic send_frame(input int len, input bit good, input bit cut);
    int stop;
    send_byte(sync_reg);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[7:0]);
    if (len > MAX_PAYLOAD) return;
    stop = cut ? $urandom_range(0, len) : len;
    for (int k = 0; k < stop; k++) send_byte(8'($urandom_range(0, 255)));
    if (cut) return;
    send_byte(good ? crc_acc : (crc_acc ^ 8'($urandom_range(1, 255))));
  endtask

  task automatic send_random_frame();
    int pick;
    int sel;
    int len;
    pick = $urandom_range(0, 99);
    // stray noise byte
    if (pick < 8) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 19);
    if (pick < 16)      len = $urandom_range(MAX_PAYLOAD + 1, 255);
    else if (sel == 0)  len = 0;
    else if (sel < 16)  len = $urandom_range(1, 8);
    else if (sel < 19)  len = $urandom_range(9, MAX_PAYLOAD - 1);
    else                len = MAX_PAYLOAD;
    send_frame(len, pick >= 30, pick >= 16 && pick < 20);
  endtask

  // drop valid and wait for every queued result to come out
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // APB write then read-back of one register
  task automatic program_reg(input logic [2:0] addr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == SYNC_ADDR) sync_reg = val;
    else seed_reg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("register readback", {24'h0, val}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // result beat check against the oldest expectation
  always @(posedge clk) begin : result_check
    rx_result_t got;
    rx_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.ev    = out_ch.event_res;
      got.ftype = out_ch.frame_type;
      got.flen  = out_ch.frame_len;
      got.data  = out_ch.data_byte;
      got.idx   = out_ch.byte_index;
      got.last  = out_ch.last;
      got.stats.bytes_seen      = out_ch.bytes_seen;
      got.stats.frames_good     = out_ch.frames_good;
      got.stats.sync_misses     = out_ch.sync_misses;
      got.stats.crc_failures    = out_ch.crc_failures;
      got.stats.length_overruns = out_ch.length_overruns;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: event %0d type %0h len %0d",
                   got.ev, got.ftype, got.flen);
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 32'(want.ev), 32'(got.ev));
        check_field("frame_type", 32'(want.ftype), 32'(got.ftype));
        check_field("frame_len", 32'(want.flen), 32'(got.flen));
        check_field("data_byte", 32'(want.data), 32'(got.data));
        check_field("byte_index", 32'(want.idx), 32'(got.idx));
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("bytes_seen", want.stats.bytes_seen, got.stats.bytes_seen);
        check_field("frames_good", want.stats.frames_good, got.stats.frames_good);
        check_field("sync_misses", want.stats.sync_misses, got.stats.sync_misses);
        check_field("crc_failures", want.stats.crc_failures, got.stats.crc_failures);
        check_field("length_overruns", want.stats.length_overruns,
                    got.stats.length_overruns);
      end
    end
  end

  // output ready: random stall bursts, plus long holds on request
  initial begin : sink_ready
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   row;
    logic [7:0] b;
    logic [7:0] phase_sync [5];
    logic [7:0] phase_seed [5];
    int         phase_start;

    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    idle_en       = 1'b1;
    hold_cycles   = 0;
    mismatch_count = 0;
    bytes_sent    = 0;

    rx_phase = RX_HUNT;
    cur_type = '0;
    cur_len  = '0;
    fill_pos = '0;
    crc_acc  = '0;
    tally    = '0;
    sync_reg = SYNC_RESET;
    seed_reg = SEED_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_RAW:      b = row.value;
        ROW_GOOD_CRC: b = crc_acc;
        default:      b = crc_acc ^ row.value;
      endcase
      send_byte(b);
      if (row.typed) begin
        check_field("directed event", 32'(row.ev), 32'(newest_result.ev));
        check_field("directed length", 32'(row.flen), 32'(newest_result.flen));
      end
    end

    // seed change mid-frame: taken at the type byte, not before or after
    wait_drain();
    send_byte(sync_reg);
    wait_drain();
    repeat (16) @(posedge clk);
    program_reg(SEED_ADDR, 8'h5A);
    send_byte(8'hC7);
    wait_drain();
    repeat (16) @(posedge clk);
    program_reg(SEED_ADDR, 8'hC3);
    send_byte(8'd2);
    send_byte(8'h11);
    send_byte(8'hEE);
    send_byte(crc_acc);

    phase_sync = '{SYNC_RESET, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h5A};
    phase_seed = '{SEED_RESET, 8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h3C};

    // random traffic, one register setting per phase
    for (int p = 0; p < 5; p++) begin
      wait_drain();
      repeat (16) @(posedge clk);
      program_reg(SYNC_ADDR, phase_sync[p]);
      program_reg(SEED_ADDR, phase_seed[p]);
      idle_en = (p != 4);
      if (p == 2) begin
        // long output hold while full frames keep coming in
        hold_cycles = 400;
        for (int k = 0; k < 2; k++) send_frame(MAX_PAYLOAD, 1'b1, 1'b0);
        wait_drain();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 36) begin
        if (p != 4) idle_en = ($urandom_range(0, 3) != 0);
        send_random_frame();
      end
    end

    wait_drain();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/fsrc_pkg.sv
src/fsrc_in_if.sv
src/fsrc_out_if.sv
src/fsrc_front.sv
src/fsrc_job_q.sv
src/fsrc_back.sv
src/framed_serial_receiver_crc8.sv
tb/sv/tb_framed_serial_receiver_crc8.sv
